// ===== design/bsc_pkg.sv =====
// Shared definitions for the barometric sensor compensation core:
// register indexes, result limits and fixed coefficients.
// No dependencies.
package bsc_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int RAW_W       = 24;
  localparam int TEMP_W      = 15;
  localparam int PRES_W      = 17;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cal_word_t;

  localparam cfg_index_t REG_PRESSURE_SENSITIVITY = 3'd0;
  localparam cfg_index_t REG_PRESSURE_OFFSET      = 3'd1;
  localparam cfg_index_t REG_SENS_TEMP_COEFF      = 3'd2;
  localparam cfg_index_t REG_OFFSET_TEMP_COEFF    = 3'd3;
  localparam cfg_index_t REG_REFERENCE_TEMP       = 3'd4;
  localparam cfg_index_t REG_TEMP_COEFF           = 3'd5;

  // temperature base (20.00 C) and the distance from it to -15.00 C
  localparam logic signed [19:0] TEMP_BASE      = 20'sd2000;
  localparam logic signed [19:0] TEMP_COLD_DIST = 20'sd3500;

  localparam logic signed [19:0] TEMP_MIN = -20'sd4000;
  localparam logic signed [19:0] TEMP_MAX = 20'sd8500;
  localparam logic signed [30:0] PRES_MIN = 31'sd1000;
  localparam logic signed [30:0] PRES_MAX = 31'sd120000;

endpackage

// ===== design/baro_sensor_compensation_core.sv =====
// Barometric sensor compensation core: second-order integer compensation
// of raw pressure and temperature conversions, nine register stages.
// Depends on bsc_pkg.

// One request (a pressure and a temperature conversion) can be accepted in
// every cycle with in_ready high; its result then waits in the
// output stage until taken. Each stage holds its request independently, so a
// stalled output only holds the stages that are full behind it. The depth is
// set by the product chain: offset and sensitivity products, the square
// terms of the low-temperature correction, and a final 24 by 41 bit product
// split into two partial products over two stages. Calibration words are
// written through cfg_we, cfg_index and cfg_data and must only change while
// no request is in flight; unknown indexes are ignored.
module baro_sensor_compensation_core
  import bsc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  cfg_index_t               cfg_index,
  input  cal_word_t                cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [RAW_W-1:0]         raw_pressure_count,
  input  logic [RAW_W-1:0]         raw_temp_count,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TEMP_W-1:0] temp_centi_c,
  output logic [PRES_W-1:0]        pressure_centi_mbar,
  output logic                     clamped
);

  localparam int NSTAGE = 9;

  cal_word_t pressure_sensitivity;
  cal_word_t pressure_offset;
  cal_word_t sens_temp_coeff;
  cal_word_t offset_temp_coeff;
  cal_word_t reference_temp;
  cal_word_t temp_coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_sensitivity <= '0;
      pressure_offset      <= '0;
      sens_temp_coeff      <= '0;
      offset_temp_coeff    <= '0;
      reference_temp       <= '0;
      temp_coeff           <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRESSURE_SENSITIVITY: pressure_sensitivity <= cfg_data;
        REG_PRESSURE_OFFSET:      pressure_offset      <= cfg_data;
        REG_SENS_TEMP_COEFF:      sens_temp_coeff      <= cfg_data;
        REG_OFFSET_TEMP_COEFF:    offset_temp_coeff    <= cfg_data;
        REG_REFERENCE_TEMP:       reference_temp       <= cfg_data;
        REG_TEMP_COEFF:           temp_coeff           <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage advance
  logic [NSTAGE:1] vld;
  logic [NSTAGE:1] adv;

  always_comb begin
    adv[NSTAGE] = !vld[NSTAGE] || out_ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = vld[NSTAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: temperature difference
  logic [RAW_W-1:0]   s1_d1;
  logic signed [24:0] s1_dt;
  logic signed [24:0] dt;

  assign dt = $signed({1'b0, raw_temp_count}) - $signed({1'b0, reference_temp, 8'd0});

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_d1 <= raw_pressure_count;
      s1_dt <= dt;
    end
  end

  // stage 2: linear products and dT squared
  logic [RAW_W-1:0]   s2_d1;
  logic signed [41:0] s2_pt;
  logic signed [41:0] s2_po;
  logic signed [41:0] s2_ps;
  logic signed [49:0] s2_dtsq;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_d1   <= s1_d1;
      s2_pt   <= s1_dt * $signed({1'b0, temp_coeff});
      s2_po   <= s1_dt * $signed({1'b0, offset_temp_coeff});
      s2_ps   <= s1_dt * $signed({1'b0, sens_temp_coeff});
      s2_dtsq <= s1_dt * s1_dt;
    end
  end

  // stage 3: first-order offset, sensitivity and temperature terms
  logic [RAW_W-1:0]   s3_d1;
  logic signed [18:0] s3_a;
  logic signed [19:0] s3_b;
  logic signed [35:0] s3_off;
  logic signed [34:0] s3_sens;
  logic [16:0]        s3_t2;
  logic signed [18:0] a;
  logic signed [35:0] off;
  logic signed [34:0] sens;

  assign a    = s2_pt[41:23];
  assign off  = $signed({4'd0, pressure_offset, 16'd0}) + $signed({s2_po[41], s2_po[41:7]});
  assign sens = $signed({4'd0, pressure_sensitivity, 15'd0}) + $signed({s2_ps[41], s2_ps[41:8]});

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_d1   <= s2_d1;
      s3_a    <= a;
      s3_b    <= $signed({a[18], a}) + TEMP_COLD_DIST;
      s3_off  <= off;
      s3_sens <= sens;
      s3_t2   <= s2_dtsq[47:31];
    end
  end

  // stage 4: squares for the low-temperature correction
  logic [RAW_W-1:0]   s4_d1;
  logic signed [18:0] s4_a;
  logic signed [35:0] s4_off;
  logic signed [34:0] s4_sens;
  logic [16:0]        s4_t2;
  logic               s4_cool;
  logic               s4_cold;
  logic [34:0]        s4_sq;
  logic [35:0]        s4_sq2;
  logic signed [37:0] sq_full;
  logic signed [39:0] sq2_full;

  assign sq_full  = s3_a * s3_a;
  assign sq2_full = s3_b * s3_b;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_d1   <= s3_d1;
      s4_a    <= s3_a;
      s4_off  <= s3_off;
      s4_sens <= s3_sens;
      s4_t2   <= s3_t2;
      s4_cool <= s3_a[18];
      s4_cold <= s3_b[19];
      s4_sq   <= sq_full[34:0];
      s4_sq2  <= sq2_full[35:0];
    end
  end

  // stage 5: second-order corrections and final temperature
  logic [RAW_W-1:0]   s5_d1;
  logic signed [35:0] s5_off;
  logic signed [34:0] s5_sens;
  logic [39:0]        s5_off2;
  logic [39:0]        s5_sens2;
  logic signed [19:0] s5_temp;
  logic [37:0]        sq5;
  logic [38:0]        sq2_7;
  logic [39:0]        sq2_11;
  logic [39:0]        off2;
  logic [39:0]        sens2;
  logic [19:0]        t2_sub;

  always_comb begin
    sq5    = {3'd0, s4_sq} + {1'b0, s4_sq, 2'd0};
    sq2_7  = {s4_sq2, 3'd0} - {3'd0, s4_sq2};
    sq2_11 = {1'b0, s4_sq2, 3'd0} + {3'd0, s4_sq2, 1'b0} + {4'd0, s4_sq2};
    off2   = {3'd0, sq5[37:1]};
    sens2  = {4'd0, sq5[37:2]};
    if (s4_cold) begin
      off2  = off2 + {1'b0, sq2_7};
      sens2 = sens2 + {1'b0, sq2_11[39:1]};
    end
    t2_sub = {3'd0, s4_t2};
    if (!s4_cool) begin
      off2   = '0;
      sens2  = '0;
      t2_sub = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_d1    <= s4_d1;
      s5_off   <= s4_off;
      s5_sens  <= s4_sens;
      s5_off2  <= off2;
      s5_sens2 <= sens2;
      s5_temp  <= TEMP_BASE + $signed({s4_a[18], s4_a}) - $signed(t2_sub);
    end
  end

  // stage 6: corrected offset and sensitivity
  logic [RAW_W-1:0]   s6_d1;
  logic signed [19:0] s6_temp;
  logic signed [40:0] s6_off;
  logic signed [40:0] s6_sens;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_d1   <= s5_d1;
      s6_temp <= s5_temp;
      s6_off  <= $signed({{5{s5_off[35]}}, s5_off}) - $signed({1'b0, s5_off2});
      s6_sens <= $signed({{6{s5_sens[34]}}, s5_sens}) - $signed({1'b0, s5_sens2});
    end
  end

  // stage 7: partial products of D1 times sensitivity
  logic signed [19:0] s7_temp;
  logic signed [40:0] s7_off;
  logic [43:0]        s7_plo;
  logic signed [45:0] s7_phi;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_temp <= s6_temp;
      s7_off  <= s6_off;
      s7_plo  <= s6_d1 * s6_sens[19:0];
      s7_phi  <= $signed({1'b0, s6_d1}) * $signed(s6_sens[40:20]);
    end
  end

  // stage 8: combine partial products, keep the floor of the 2^21 scale
  logic signed [19:0] s8_temp;
  logic signed [40:0] s8_off;
  logic signed [44:0] s8_pq;
  logic signed [65:0] prod;

  assign prod = $signed({s7_phi, 20'd0}) + $signed({22'd0, s7_plo});

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s8_temp <= s7_temp;
      s8_off  <= s7_off;
      s8_pq   <= prod[65:21];
    end
  end

  // stage 9: pressure, clamp and output hold
  logic signed [45:0] pdiff;
  logic signed [30:0] pres;
  logic signed [19:0] temp_cl;
  logic signed [30:0] pres_cl;
  logic               clamp_flag;

  always_comb begin
    pdiff      = $signed({s8_pq[44], s8_pq}) - $signed({{5{s8_off[40]}}, s8_off});
    pres       = pdiff[45:15];
    temp_cl    = s8_temp;
    pres_cl    = pres;
    clamp_flag = 1'b0;
    if (s8_temp < TEMP_MIN) begin
      temp_cl    = TEMP_MIN;
      clamp_flag = 1'b1;
    end
    if (s8_temp > TEMP_MAX) begin
      temp_cl    = TEMP_MAX;
      clamp_flag = 1'b1;
    end
    if (pres < PRES_MIN) begin
      pres_cl    = PRES_MIN;
      clamp_flag = 1'b1;
    end
    if (pres > PRES_MAX) begin
      pres_cl    = PRES_MAX;
      clamp_flag = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      temp_centi_c        <= temp_cl[TEMP_W-1:0];
      pressure_centi_mbar <= pres_cl[PRES_W-1:0];
      clamped             <= clamp_flag;
    end
  end

  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output stage");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[1])
    else $error("accepted request lost at first stage");

  a_pres_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pressure_centi_mbar >= PRES_W'(1000) && pressure_centi_mbar <= PRES_W'(120000))
    else $error("pressure outside its range");

  a_clamp_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && clamped |->
      temp_centi_c == -15'sd4000 || temp_centi_c == 15'sd8500 ||
      pressure_centi_mbar == PRES_W'(1000) || pressure_centi_mbar == PRES_W'(120000))
    else $error("clamp flag set with no value at a bound");

endmodule
